### src/sgdm_pkg.sv
package sgdm_pkg;

  // Configuration port
  localparam int unsigned PADDR_W = 5;

  localparam logic [2:0] REG_MODE      = 3'd0;
  localparam logic [2:0] REG_MOMENTUM  = 3'd1;
  localparam logic [2:0] REG_LRATE     = 3'd2;
  localparam logic [2:0] REG_DECAY     = 3'd3;
  localparam logic [2:0] REG_CORR_NOW  = 3'd4;
  localparam logic [2:0] REG_CORR_PREV = 3'd5;

  // Update modes; the unused code behaves as plain SGD
  localparam logic [1:0] SGD_MC   = 2'd1;
  localparam logic [1:0] NESTEROV = 2'd2;

  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

  localparam logic signed [31:0] INT32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] INT32_MIN = 32'sh8000_0000;

  // Register stages of each datapath section
  localparam int unsigned COEF_STAGES = 2;
  localparam int unsigned INCR_STAGES = 8;
  localparam int unsigned WUPD_STAGES = 5;
  localparam int unsigned NSTAGES     = COEF_STAGES + INCR_STAGES + WUPD_STAGES;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] momentum;
    logic [31:0] learning_rate;
    logic [31:0] weight_decay;
    logic [31:0] correction_now;
    logic [31:0] correction_prev;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] weight;
    logic signed [31:0] increment;
    logic signed [31:0] gradient;
    logic               last;
  } item_t;

  // Per-item coefficients, Q.30
  typedef struct packed {
    item_t       item;
    logic [33:0] mc;
    logic [33:0] mc2;
    logic [39:0] dd;
    logic [39:0] lrr;
  } coef_t;

  typedef struct packed {
    item_t              item;
    logic signed [31:0] ninc;
    logic               sat;
    logic signed [36:0] im2;
    logic [34:0]        mcp;
  } incr_t;

  typedef struct packed {
    logic signed [31:0] new_weight;
    logic signed [31:0] new_increment;
    logic               saturated;
    logic               last;
  } res_t;

  typedef struct packed {
    logic               sat;
    logic signed [31:0] val;
  } clip_t;

  // Clamp to the signed 32-bit range and flag a clip
  function automatic clip_t clip32(input logic signed [55:0] v);
    clip_t r;
    r.sat = 1'b0;
    r.val = v[31:0];
    if (v > 56'(INT32_MAX)) begin
      r.sat = 1'b1;
      r.val = INT32_MAX;
    end else if (v < 56'(INT32_MIN)) begin
      r.sat = 1'b1;
      r.val = INT32_MIN;
    end
    return r;
  endfunction

endpackage

### src/sgdm_if.sv
interface sgdm_item_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] weight;
  logic signed [31:0] increment;
  logic signed [31:0] gradient;
  logic [31:0]        rate_scale;
  logic [31:0]        decay_scale;
  logic               last_in;

  modport source (
    output valid, weight, increment, gradient, rate_scale, decay_scale, last_in,
    input  ready
  );
  modport sink (
    input  valid, weight, increment, gradient, rate_scale, decay_scale, last_in,
    output ready
  );
endinterface

interface sgdm_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_weight;
  logic signed [31:0] new_increment;
  logic               saturated;
  logic               last_out;

  modport source (
    output valid, new_weight, new_increment, saturated, last_out,
    input  ready
  );
  modport sink (
    input  valid, new_weight, new_increment, saturated, last_out,
    output ready
  );
endinterface

### src/sgdm_coef.sv
module sgdm_coef (
  input  logic                                clk,
  input  logic [sgdm_pkg::COEF_STAGES-1:0]    en,
  input  sgdm_pkg::cfg_t                      cfg,
  input  sgdm_pkg::item_t                     item,
  input  logic [31:0]                         rate_scale,
  input  logic [31:0]                         decay_scale,
  output sgdm_pkg::coef_t                     c
);
  import sgdm_pkg::*;

  logic [63:0] s1_pm, s1_pm2, s1_pd, s1_pl;
  item_t       s1_item, s2_item;
  logic [63:0] pm_r, pm2_r, pd_r, pl_r;
  logic [33:0] s2_mc, s2_mc2;
  logic [39:0] s2_dd, s2_lrr;

  // Stage 1: raw coefficient products
  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_pm   <= cfg.momentum * cfg.correction_now;
      s1_pm2  <= cfg.momentum * cfg.correction_prev;
      s1_pd   <= cfg.weight_decay * decay_scale;
      s1_pl   <= cfg.learning_rate * rate_scale;
      s1_item <= item;
    end
  end

  // Round to nearest (operands are non-negative)
  assign pm_r  = s1_pm  + {34'd0, 1'b1, 29'd0};
  assign pm2_r = s1_pm2 + {34'd0, 1'b1, 29'd0};
  assign pd_r  = s1_pd  + {40'd0, 1'b1, 23'd0};
  assign pl_r  = s1_pl  + {40'd0, 1'b1, 23'd0};

  // Stage 2: scaled coefficients
  always_ff @(posedge clk) begin
    if (en[1]) begin
      if (cfg.mode inside {SGD_MC, NESTEROV}) begin
        s2_mc <= pm_r[63:30];
      end else begin
        s2_mc <= {2'b00, cfg.momentum};
      end
      s2_mc2  <= pm2_r[63:30];
      s2_dd   <= pd_r[63:24];
      s2_lrr  <= pl_r[63:24];
      s2_item <= s1_item;
    end
  end

  assign c = '{item: s2_item, mc: s2_mc, mc2: s2_mc2, dd: s2_dd, lrr: s2_lrr};

endmodule

### src/sgdm_incr.sv
module sgdm_incr (
  input  logic                                clk,
  input  logic [sgdm_pkg::INCR_STAGES-1:0]    en,
  input  sgdm_pkg::coef_t                     c,
  output sgdm_pkg::incr_t                     r
);
  import sgdm_pkg::*;

  item_t              item_q [INCR_STAGES];

  logic signed [32:0] dd_lo, mc_lo, mc2_lo;
  logic signed [8:0]  dd_hi;
  logic signed [2:0]  mc_hi, mc2_hi;

  logic signed [64:0] s3_pw_lo, s3_pi_lo, s3_pj_lo;
  logic signed [40:0] s3_pw_hi;
  logic signed [34:0] s3_pi_hi, s3_pj_hi;
  logic [39:0]        s3_lrr, s4_lrr, s5_lrr, s6_lrr;
  logic [34:0]        s3_mcp, s4_mcp, s5_mcp, s6_mcp, s7_mcp, s8_mcp, s9_mcp, s10_mcp;

  logic signed [72:0] s4_pw, pw_adj;
  logic signed [66:0] s4_pi, s4_pj, pi_adj, pj_adj;

  logic signed [42:0] s5_wt;
  logic signed [36:0] s5_im, s6_im, s7_im, s8_im, s9_im;
  logic signed [36:0] s5_im2, s6_im2, s7_im2, s8_im2, s9_im2, s10_im2;

  logic signed [43:0] s6_g;
  logic [63:0]        s7_q0;
  logic [39:0]        s7_q1;
  logic signed [44:0] s7_q2;
  logic signed [20:0] s7_q3;
  logic signed [84:0] s8_pg, pg_adj;
  logic signed [54:0] s9_gl;
  logic signed [55:0] inc_sum;
  clip_t              inc_clip;
  logic signed [31:0] s10_ninc;
  logic               s10_sat;

  assign dd_lo  = {1'b0, c.dd[31:0]};
  assign dd_hi  = {1'b0, c.dd[39:32]};
  assign mc_lo  = {1'b0, c.mc[31:0]};
  assign mc_hi  = {1'b0, c.mc[33:32]};
  assign mc2_lo = {1'b0, c.mc2[31:0]};
  assign mc2_hi = {1'b0, c.mc2[33:32]};

  // Item fields travel alongside
  always_ff @(posedge clk) begin
    if (en[0]) begin
      item_q[0] <= c.item;
    end
    for (int i = 1; i < INCR_STAGES; i++) begin
      if (en[i]) begin
        item_q[i] <= item_q[i-1];
      end
    end
  end

  // Round half away from zero: bias is 2^29, less one for negatives
  assign pw_adj = s4_pw + $signed({43'd0, ~s4_pw[72], {29{s4_pw[72]}}});
  assign pi_adj = s4_pi + $signed({37'd0, ~s4_pi[66], {29{s4_pi[66]}}});
  assign pj_adj = s4_pj + $signed({37'd0, ~s4_pj[66], {29{s4_pj[66]}}});
  assign pg_adj = s8_pg + $signed({55'd0, ~s8_pg[84], {29{s8_pg[84]}}});

  assign inc_sum  = 56'(s9_gl) + 56'(s9_im);
  assign inc_clip = clip32(inc_sum);

  always_ff @(posedge clk) begin
    // Stage 3: split partial products
    if (en[0]) begin
      s3_pw_lo <= c.item.weight * dd_lo;
      s3_pw_hi <= c.item.weight * dd_hi;
      s3_pi_lo <= c.item.increment * mc_lo;
      s3_pi_hi <= c.item.increment * mc_hi;
      s3_pj_lo <= c.item.increment * mc2_lo;
      s3_pj_hi <= c.item.increment * mc2_hi;
      s3_lrr   <= c.lrr;
      s3_mcp   <= 35'(c.mc) + 35'(ONE_Q30);
    end
    // Stage 4: combine partials
    if (en[1]) begin
      s4_pw  <= 73'(s3_pw_lo) + $signed({s3_pw_hi, 32'd0});
      s4_pi  <= 67'(s3_pi_lo) + $signed({s3_pi_hi, 32'd0});
      s4_pj  <= 67'(s3_pj_lo) + $signed({s3_pj_hi, 32'd0});
      s4_lrr <= s3_lrr;
      s4_mcp <= s3_mcp;
    end
    // Stage 5: back to Q.24
    if (en[2]) begin
      s5_wt  <= pw_adj[72:30];
      s5_im  <= pi_adj[66:30];
      s5_im2 <= pj_adj[66:30];
      s5_lrr <= s4_lrr;
      s5_mcp <= s4_mcp;
    end
    // Stage 6: decayed gradient
    if (en[3]) begin
      s6_g   <= 44'(item_q[2].gradient) + 44'(s5_wt);
      s6_im  <= s5_im;
      s6_im2 <= s5_im2;
      s6_lrr <= s5_lrr;
      s6_mcp <= s5_mcp;
    end
    // Stage 7: gradient times rate, four partials
    if (en[4]) begin
      s7_q0  <= s6_g[31:0] * s6_lrr[31:0];
      s7_q1  <= s6_g[31:0] * s6_lrr[39:32];
      s7_q2  <= $signed(s6_g[43:32]) * $signed({1'b0, s6_lrr[31:0]});
      s7_q3  <= $signed(s6_g[43:32]) * $signed({1'b0, s6_lrr[39:32]});
      s7_im  <= s6_im;
      s7_im2 <= s6_im2;
      s7_mcp <= s6_mcp;
    end
    // Stage 8
    if (en[5]) begin
      s8_pg  <= $signed({21'd0, s7_q0}) + $signed({13'd0, s7_q1, 32'd0})
              + $signed({{8{s7_q2[44]}}, s7_q2, 32'd0}) + $signed({s7_q3, 64'd0});
      s8_im  <= s7_im;
      s8_im2 <= s7_im2;
      s8_mcp <= s7_mcp;
    end
    // Stage 9
    if (en[6]) begin
      s9_gl  <= pg_adj[84:30];
      s9_im  <= s8_im;
      s9_im2 <= s8_im2;
      s9_mcp <= s8_mcp;
    end
    // Stage 10: new increment, clamped
    if (en[7]) begin
      s10_ninc <= inc_clip.val;
      s10_sat  <= inc_clip.sat;
      s10_im2  <= s9_im2;
      s10_mcp  <= s9_mcp;
    end
  end

  assign r = '{item: item_q[INCR_STAGES-1], ninc: s10_ninc, sat: s10_sat,
               im2: s10_im2, mcp: s10_mcp};

endmodule

### src/sgdm_wupd.sv
module sgdm_wupd (
  input  logic                                clk,
  input  logic [sgdm_pkg::WUPD_STAGES-1:0]    en,
  input  logic [1:0]                          mode,
  input  sgdm_pkg::incr_t                     r,
  output sgdm_pkg::res_t                      res
);
  import sgdm_pkg::*;

  incr_t              rq [WUPD_STAGES-1];

  logic signed [64:0] s11_n_lo;
  logic signed [35:0] s11_n_hi;
  logic signed [67:0] s12_pn, pn_adj;
  logic signed [37:0] s13_rn;
  logic signed [39:0] s14_d;
  clip_t              w_clip;
  res_t               s15_res;

  // Carry the incoming item and increment results
  always_ff @(posedge clk) begin
    if (en[0]) begin
      rq[0] <= r;
    end
    for (int i = 1; i < WUPD_STAGES - 1; i++) begin
      if (en[i]) begin
        rq[i] <= rq[i-1];
      end
    end
  end

  assign pn_adj = s12_pn + $signed({38'd0, ~s12_pn[67], {29{s12_pn[67]}}});
  assign w_clip = clip32(56'(s14_d));

  always_ff @(posedge clk) begin
    // Stage 11: new increment times (1 + mc)
    if (en[0]) begin
      s11_n_lo <= r.ninc * $signed({1'b0, r.mcp[31:0]});
      s11_n_hi <= r.ninc * $signed({1'b0, r.mcp[34:32]});
    end
    if (en[1]) begin
      s12_pn <= 68'(s11_n_lo) + $signed({s11_n_hi, 32'd0});
    end
    if (en[2]) begin
      s13_rn <= pn_adj[67:30];
    end
    // Stage 14: weight step
    if (en[3]) begin
      if (mode == NESTEROV) begin
        s14_d <= 40'(rq[2].item.weight) - 40'(s13_rn) + 40'(rq[2].im2);
      end else begin
        s14_d <= 40'(rq[2].item.weight) - 40'(rq[2].ninc);
      end
    end
    // Stage 15: result register
    if (en[4]) begin
      s15_res.new_weight    <= w_clip.val;
      s15_res.new_increment <= rq[3].ninc;
      s15_res.saturated     <= rq[3].sat | w_clip.sat;
      s15_res.last          <= rq[3].item.last;
    end
  end

  assign res = s15_res;

endmodule

### src/sgd_momentum_weight_update.sv
// Momentum SGD weight update, one weight per transfer. Each item carries a
// weight, its stored momentum increment, its gradient and per-element rate
// and decay multipliers; the result carries the new weight and the new
// increment, both clamped to the signed Q8.24 range, a flag set when either
// was clamped, and the end-of-tensor mark copied through. Plain SGD, SGD
// with corrected momentum and Nesterov are chosen by update_mode (code 3
// acts as plain SGD). The datapath is a fifteen-stage pipeline with
// coefficient, increment and weight-update sections; a new item is taken
// every cycle unless every stage is full and the result is held. Each
// stage holds its data when the stage after it is full and stalled, so
// bubbles close up and the input keeps taking items while a finished
// result waits for its transfer. Registers sit on an APB port at byte
// address 4*i: 0 update_mode, 1 momentum, 2 learning_rate,
// 3 weight_decay, 4 correction_now, 5 correction_prev (all but update_mode
// unsigned Q2.30). Write them only while no item is in flight.
module sgd_momentum_weight_update (
  input  logic                            clk,
  input  logic                            rst,
  sgdm_item_if.sink                       items,
  sgdm_result_if.source                   results,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sgdm_pkg::PADDR_W-1:0]    paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import sgdm_pkg::*;

  localparam int unsigned INCR_LO = COEF_STAGES + 1;
  localparam int unsigned INCR_HI = COEF_STAGES + INCR_STAGES;
  localparam int unsigned WUPD_LO = INCR_HI + 1;

  cfg_t               cfg;
  logic               cfg_wr;
  logic [2:0]         reg_idx;

  logic [NSTAGES:1]   vld;
  logic [NSTAGES:1]   vld_in;
  logic [NSTAGES+1:1] adv;

  item_t              item;
  coef_t              coef;
  incr_t              incr;
  res_t               res;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode            <= '0;
      cfg.momentum        <= '0;
      cfg.learning_rate   <= '0;
      cfg.weight_decay    <= '0;
      cfg.correction_now  <= ONE_Q30;
      cfg.correction_prev <= ONE_Q30;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_MODE:      cfg.mode            <= pwdata[1:0];
        REG_MOMENTUM:  cfg.momentum        <= pwdata;
        REG_LRATE:     cfg.learning_rate   <= pwdata;
        REG_DECAY:     cfg.weight_decay    <= pwdata;
        REG_CORR_NOW:  cfg.correction_now  <= pwdata;
        REG_CORR_PREV: cfg.correction_prev <= pwdata;
        default: ; // drop writes beyond the register file
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MODE:      prdata = {30'd0, cfg.mode};
      REG_MOMENTUM:  prdata = cfg.momentum;
      REG_LRATE:     prdata = cfg.learning_rate;
      REG_DECAY:     prdata = cfg.weight_decay;
      REG_CORR_NOW:  prdata = cfg.correction_now;
      REG_CORR_PREV: prdata = cfg.correction_prev;
      default:       prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Pipeline control: a stage advances when it is empty or the stage after
  // it advances; the last stage advances on a result transfer.
  // ---------------------------------------------------------------------
  always_comb begin
    adv[NSTAGES+1] = results.ready;
    for (int i = NSTAGES; i >= 1; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  assign vld_in = {vld[NSTAGES-1:1], items.valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 1; i <= NSTAGES; i++) begin
        if (adv[i]) begin
          vld[i] <= vld_in[i];
        end
      end
    end
  end

  assign items.ready = adv[1];

  // ---------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------
  assign item = '{weight: items.weight, increment: items.increment,
                  gradient: items.gradient, last: items.last_in};

  // Stages 1-2: mc, mc2, decay and rate coefficients
  sgdm_coef u_coef (
    .clk         (clk),
    .en          (adv[COEF_STAGES:1]),
    .cfg         (cfg),
    .item        (item),
    .rate_scale  (items.rate_scale),
    .decay_scale (items.decay_scale),
    .c           (coef)
  );

  // Stages 3-10: new increment
  sgdm_incr u_incr (
    .clk (clk),
    .en  (adv[INCR_HI:INCR_LO]),
    .c   (coef),
    .r   (incr)
  );

  // Stages 11-15: weight step and result register
  sgdm_wupd u_wupd (
    .clk  (clk),
    .en   (adv[NSTAGES:WUPD_LO]),
    .mode (cfg.mode),
    .r    (incr),
    .res  (res)
  );

  assign results.valid         = vld[NSTAGES];
  assign results.new_weight    = res.new_weight;
  assign results.new_increment = res.new_increment;
  assign results.saturated     = res.saturated;
  assign results.last_out      = res.last;

`ifndef SYNTHESIS
  // Input stalls only when every stage is full and the result is held
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !items.ready |-> (vld == '1) && results.valid && !results.ready)
    else $error("input stalled with room in the pipeline");

  // An accepted item lands in the first stage
  a_enter: assert property (@(posedge clk) disable iff (rst)
    items.valid && items.ready |=> vld[1])
    else $error("accepted item lost at pipeline entry");

  // No result straight after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !results.valid)
    else $error("result valid after reset");

  // A saturation flag implies a clamped field
  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.saturated |->
      (results.new_weight == INT32_MAX) || (results.new_weight == INT32_MIN) ||
      (results.new_increment == INT32_MAX) || (results.new_increment == INT32_MIN))
    else $error("saturation flag without a clamped result");
`endif

endmodule
